// ===== hw/rtl/ailf_pkg.sv =====
package ailf_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int S_TDATA_W       = 104;
    localparam int M_TDATA_W       = 32;
    localparam int DIV_STEPS       = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_POINTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd4;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_POINT  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FAIL  = 2'd1;
    localparam logic [1:0] STATUS_POINT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE_MUL,
        ST_SCALE_ADD,
        ST_FIRST,
        ST_LAST,
        ST_WALK,
        ST_DIV,
        ST_INT_MUL,
        ST_INT_FIN,
        ST_FILT_MUL,
        ST_FILT_UPD,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hw/rtl/analog_input_linearize_filter_unit.sv =====
// Analog input linearizer: one request at a time. A point write or a failed read (negative
// sample) goes straight to ST_OUT; a scale/offset sample passes ST_SCALE_MUL, ST_SCALE_ADD.
// With a table in use the table memory is read one entry per cycle (first, last, then a
// walk over the points); a sample inside a segment then runs the bit-per-cycle divider,
// ST_INT_MUL and ST_INT_FIN. One result per request; a result waiting on the output does
// not block accepting the next request, whose result then waits in ST_OUT until taken.
module analog_input_linearize_filter_unit #(
    parameter int TABLE_DEPTH = ailf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ailf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ailf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample_voltage, point_index, point_x, point_y, zero pad
    input  logic [ailf_pkg::S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // filtered_value
    output logic [ailf_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [1:0]                      m_tuser
);
    import ailf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = $clog2(DIV_STEPS + 1);

    logic [63:0] mem [TABLE_DEPTH];
    logic [63:0] rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic        current_mode_reg;
    logic [4:0]  table_points_reg;
    logic signed [31:0] scale_reg;
    logic signed [31:0] offset_reg;
    logic [15:0] alpha_reg;

    state_t state_reg, state_next;
    logic signed [31:0] filter_reg, filter_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] prev_x_reg, prev_x_next;
    logic signed [31:0] prev_y_reg, prev_y_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [23:0] t_reg, t_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic signed [31:0] y0_reg, y0_next;
    logic dy_neg_reg, dy_neg_next;
    logic [32:0] mag_reg, mag_next;
    logic [1:0] status_reg, status_next;
    logic out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [1:0] out_user_reg, out_user_next;

    logic signed [31:0] in_v, in_x, in_y, cur_x, cur_y, conv_v;
    logic [3:0] in_idx;
    logic [AW+3:0] idx_ext;
    logic [8:0] n_wide;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] n_last;
    logic accept, wr_en;
    logic signed [32:0] dx, dy, diff;
    logic [33:0] rem2;
    logic signed [63:0] tmp;

    assign in_v   = s_tdata[31:0];
    assign in_idx = s_tdata[35:32];
    assign in_x   = s_tdata[67:36];
    assign in_y   = s_tdata[99:68];
    assign cur_x  = rd_data_reg[31:0];
    assign cur_y  = rd_data_reg[63:32];
    assign idx_ext = {{AW{1'b0}}, in_idx};
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign wr_en = accept && (s_tuser == FUNC_POINT) && (idx_ext < (AW+4)'(TABLE_DEPTH));

    assign n_wide = ({4'd0, table_points_reg} > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH)
                                                                  : {4'd0, table_points_reg};
    assign n_eff  = n_wide[NW-1:0];
    assign n_last = n_eff - NW'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_ext[AW-1:0]] <= {in_y, in_x};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_mode_reg <= 1'b0;
            table_points_reg <= 5'd0;
            scale_reg        <= 32'sd65536;
            offset_reg       <= 32'sd0;
            alpha_reg        <= 16'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CURRENT_MODE: current_mode_reg <= cfg_wdata[0];
                REG_TABLE_POINTS: table_points_reg <= cfg_wdata[4:0];
                REG_SCALE_FACTOR: scale_reg        <= cfg_wdata;
                REG_OFFSET:       offset_reg       <= cfg_wdata;
                REG_FILTER_ALPHA: alpha_reg        <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filter_reg    <= 32'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filter_reg    <= filter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        val_reg      <= val_next;
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        idx_reg      <= idx_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        t_reg        <= t_next;
        cnt_reg      <= cnt_next;
        y0_reg       <= y0_next;
        dy_neg_reg   <= dy_neg_next;
        mag_reg      <= mag_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        filter_next    = filter_reg;
        p_next         = p_reg;
        val_next       = val_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        t_next         = t_reg;
        cnt_next       = cnt_reg;
        y0_next        = y0_reg;
        dy_neg_next    = dy_neg_reg;
        mag_next       = mag_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        rd_addr        = '0;
        dx             = {cur_x[31], cur_x} - {prev_x_reg[31], prev_x_reg};
        dy             = {cur_y[31], cur_y} - {prev_y_reg[31], prev_y_reg};
        diff           = {val_reg[31], val_reg} - {filter_reg[31], filter_reg};
        rem2           = {rem_reg, 1'b0};
        tmp            = '0;
        conv_v         = in_v;

        if (current_mode_reg)
        begin
            if (in_v < 32'sd65536)
            begin
                conv_v = 32'sd262144;
            end
            else if (in_v > 32'sd327680)
            begin
                conv_v = 32'sd1310720;
            end
            else
            begin
                conv_v = in_v <<< 2;
            end
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == FUNC_POINT)
                    begin
                        status_next = STATUS_POINT;
                        state_next  = ST_OUT;
                    end
                    else if (in_v < 0)
                    begin
                        status_next = STATUS_FAIL;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        p_next = conv_v;
                        state_next = (n_eff == '0) ? ST_SCALE_MUL : ST_FIRST;
                    end
                end
            end
            ST_SCALE_MUL:
            begin
                prod_next  = 64'(p_reg) * 64'(scale_reg);
                state_next = ST_SCALE_ADD;
            end
            ST_SCALE_ADD:
            begin
                tmp        = ((prod_reg + 64'sd32768) >>> 16) + 64'(offset_reg);
                val_next   = sat32(tmp);
                state_next = ST_FILT_MUL;
            end
            ST_FIRST:
            begin
                rd_addr = n_last[AW-1:0];
                if (p_reg <= cur_x)
                begin
                    val_next   = cur_y;
                    state_next = ST_FILT_MUL;
                end
                else
                begin
                    prev_x_next = cur_x;
                    prev_y_next = cur_y;
                    state_next  = ST_LAST;
                end
            end
            ST_LAST:
            begin
                rd_addr = AW'(1);
                idx_next = AW'(1);
                if (p_reg >= cur_x)
                begin
                    val_next   = cur_y;
                    state_next = ST_FILT_MUL;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                rd_addr = idx_reg + AW'(1);
                if (p_reg >= prev_x_reg && p_reg <= cur_x)
                begin
                    if (dx <= 0)
                    begin
                        val_next   = prev_y_reg;
                        state_next = ST_FILT_MUL;
                    end
                    else if (p_reg == cur_x)
                    begin
                        val_next   = cur_y;
                        state_next = ST_FILT_MUL;
                    end
                    else
                    begin
                        rem_next    = 33'({p_reg[31], p_reg} - {prev_x_reg[31], prev_x_reg});
                        den_next    = 33'(dx);
                        t_next      = '0;
                        cnt_next    = '0;
                        y0_next     = prev_y_reg;
                        dy_neg_next = dy[32];
                        mag_next    = dy[32] ? 33'(-dy) : 33'(dy);
                        state_next  = ST_DIV;
                    end
                end
                else if (NW'(idx_reg) == n_last)
                begin
                    val_next   = p_reg;
                    state_next = ST_FILT_MUL;
                end
                else
                begin
                    prev_x_next = cur_x;
                    prev_y_next = cur_y;
                    idx_next    = idx_reg + AW'(1);
                end
            end
            ST_DIV:
            begin
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_next = 33'(rem2 - {1'b0, den_reg});
                    t_next   = {t_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[32:0];
                    t_next   = {t_reg[22:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = ST_INT_MUL;
                end
            end
            ST_INT_MUL:
            begin
                prod_next  = 64'(mag_reg) * 64'(t_reg);
                state_next = ST_INT_FIN;
            end
            ST_INT_FIN:
            begin
                tmp = (prod_reg + 64'sd8388608) >>> 24;
                if (dy_neg_reg)
                begin
                    val_next = sat32(64'(y0_reg) - tmp);
                end
                else
                begin
                    val_next = sat32(64'(y0_reg) + tmp);
                end
                state_next = ST_FILT_MUL;
            end
            ST_FILT_MUL:
            begin
                prod_next  = 64'(signed'({1'b0, alpha_reg})) * 64'(diff);
                state_next = ST_FILT_UPD;
            end
            ST_FILT_UPD:
            begin
                tmp         = ((prod_reg + 64'sd32768) >>> 16) + 64'(filter_reg);
                filter_next = sat32(tmp);
                status_next = STATUS_OK;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = filter_reg;
                    out_user_next  = status_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ailf_checker.sv =====
module ailf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import ailf_pkg::*;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready after accepted request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_FAIL
                      || m_tuser == STATUS_POINT))
        else $error("bad status code");

    a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && s_tready && !s_tvalid |=> !m_tvalid)
        else $error("result without request");

endmodule

bind analog_input_linearize_filter_unit ailf_checker u_ailf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
